[sv/sle_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the sequential list engine: sizes, request kinds
// and status codes. No dependencies.
package sle_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic [2:0] OP_CLEAR  = 3'd0;
    localparam logic [2:0] OP_INSERT = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_SEARCH = 3'd3;
    localparam logic [2:0] OP_VISIT  = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

endpackage

[sv/sequential_list_engine.sv]
`timescale 1ns / 1ps
// Sequential list engine: ordered list held in one synchronous RAM; uses sle_pkg.
// Clear, refused and unknown requests load the result register directly; insert shifts
// the entries at or above its position up from the tail, remove shifts those above its
// position down, search scans from entry 0 until a hit or the end, and visit reads one
// entry. One request at a time, the next accepted the cycle after the result loads.
// Synchronous active-low reset clears the count and handshakes; the RAM is not cleared.
module sequential_list_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [5:0]  s_position,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [5:0]  m_found_position,
    output logic [31:0] m_read_value,
    output logic [6:0]  m_count_now
);

    localparam int AW = sle_pkg::ADDR_W;
    localparam int CW = sle_pkg::CNT_W;
    localparam int DW = sle_pkg::DATA_WIDTH;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WORK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [DW-1:0] entry_mem [sle_pkg::CAPACITY];
    logic [DW-1:0] rdata_reg;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [2:0]    op_reg, op_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [DW-1:0] word_reg, word_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] last_reg, last_next;
    logic          more_reg, more_next;
    logic          pv_reg, pv_next;
    logic [AW-1:0] pa_reg, pa_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [AW-1:0] res_found_reg, res_found_next;
    logic [DW-1:0] res_value_reg, res_value_next;

    logic          m_valid_reg, m_valid_next;
    logic [1:0]    m_status_reg, m_status_next;
    logic [5:0]    m_found_reg, m_found_next;
    logic [31:0]   m_value_reg, m_value_next;
    logic [6:0]    m_count_reg, m_count_next;

    logic          we, re;
    logic [AW-1:0] wa, ra;
    logic [DW-1:0] wd;
    logic [CW-1:0] pos_ext;

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_found_position = m_found_reg;
    assign m_read_value     = m_value_reg;
    assign m_count_now      = m_count_reg;
    assign pos_ext          = CW'(s_position);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        word_next       = word_reg;
        ptr_next        = ptr_reg;
        last_next       = last_reg;
        more_next       = more_reg;
        pv_next         = 1'b0;
        pa_next         = pa_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg;
        m_status_next   = m_status_reg;
        m_found_next    = m_found_reg;
        m_value_next    = m_value_reg;
        m_count_next    = m_count_reg;
        we = 1'b0;
        re = 1'b0;
        wa = '0;
        ra = ptr_reg;
        wd = rdata_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next         = s_req_type;
                    pos_next        = s_position;
                    word_next       = DW'(s_value);
                    res_status_next = sle_pkg::ST_OK;
                    res_found_next  = '0;
                    res_value_next  = '0;
                    state_next      = S_DONE;
                    case (s_req_type)
                        sle_pkg::OP_CLEAR: begin
                            count_next = '0;
                        end
                        sle_pkg::OP_INSERT: begin
                            if (count_reg >= CW'(sle_pkg::CAPACITY)) begin
                                res_status_next = sle_pkg::ST_FULL;
                            end else if (pos_ext > count_reg) begin
                                res_status_next = sle_pkg::ST_RANGE;
                            end else begin
                                // walk down from the tail, moving each entry up one slot
                                more_next  = (pos_ext < count_reg);
                                ptr_next   = AW'(count_reg - CW'(1));
                                last_next  = s_position;
                                state_next = S_WORK;
                            end
                        end
                        sle_pkg::OP_REMOVE: begin
                            if (pos_ext >= count_reg) begin
                                res_status_next = sle_pkg::ST_RANGE;
                            end else begin
                                more_next  = ((pos_ext + CW'(1)) < count_reg);
                                ptr_next   = s_position + AW'(1);
                                last_next  = AW'(count_reg - CW'(1));
                                state_next = S_WORK;
                            end
                        end
                        sle_pkg::OP_SEARCH: begin
                            more_next  = (count_reg != '0);
                            ptr_next   = '0;
                            last_next  = AW'(count_reg - CW'(1));
                            state_next = S_WORK;
                        end
                        sle_pkg::OP_VISIT: begin
                            if (pos_ext >= count_reg) begin
                                res_status_next = sle_pkg::ST_RANGE;
                            end else begin
                                more_next  = 1'b1;
                                ptr_next   = s_position;
                                last_next  = s_position;
                                state_next = S_WORK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WORK: begin
                // issue the next read of the sweep
                if (more_reg) begin
                    re      = 1'b1;
                    pv_next = 1'b1;
                    pa_next = ptr_reg;
                    if (ptr_reg == last_reg) begin
                        more_next = 1'b0;
                    end else if (op_reg == sle_pkg::OP_INSERT) begin
                        ptr_next = ptr_reg - AW'(1);
                    end else begin
                        ptr_next = ptr_reg + AW'(1);
                    end
                end
                case (op_reg)
                    sle_pkg::OP_INSERT: begin
                        if (pv_reg) begin
                            we = 1'b1;
                            wa = pa_reg + AW'(1);
                        end else if (!more_reg) begin
                            we         = 1'b1;
                            wa         = pos_reg;
                            wd         = word_reg;
                            count_next = count_reg + CW'(1);
                            state_next = S_DONE;
                        end
                    end
                    sle_pkg::OP_REMOVE: begin
                        if (pv_reg) begin
                            we = 1'b1;
                            wa = pa_reg - AW'(1);
                        end else if (!more_reg) begin
                            count_next = count_reg - CW'(1);
                            state_next = S_DONE;
                        end
                    end
                    sle_pkg::OP_SEARCH: begin
                        if (pv_reg && (rdata_reg == word_reg)) begin
                            res_found_next = pa_reg;
                            more_next      = 1'b0;
                            pv_next        = 1'b0;
                            re             = 1'b0;
                            state_next     = S_DONE;
                        end else if (!pv_reg && !more_reg) begin
                            res_status_next = sle_pkg::ST_NOT_FOUND;
                            state_next      = S_DONE;
                        end
                    end
                    default: begin
                        // visit: one read, then take the data
                        if (pv_reg) begin
                            res_value_next = rdata_reg;
                            state_next     = S_DONE;
                        end
                    end
                endcase
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_found_next  = 6'(res_found_reg);
                    m_value_next  = 32'(res_value_reg);
                    m_count_next  = 7'(count_reg);
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            entry_mem[wa] <= wd;
        end
        if (re) begin
            rdata_reg <= entry_mem[ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            more_reg    <= 1'b0;
            pv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            more_reg    <= more_next;
            pv_reg      <= pv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        word_reg       <= word_next;
        ptr_reg        <= ptr_next;
        last_reg       <= last_next;
        pa_reg         <= pa_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_value_reg  <= res_value_next;
        m_status_reg   <= m_status_next;
        m_found_reg    <= m_found_next;
        m_value_reg    <= m_value_next;
        m_count_reg    <= m_count_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(sle_pkg::CAPACITY))
        else $error("list count above capacity");

    a_write_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> (state_reg == S_WORK))
        else $error("RAM write outside a sweep");

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (we && re) |-> (wa != ra))
        else $error("RAM read and write hit the same entry");

    a_pipe_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        pv_reg |-> (state_reg == S_WORK))
        else $error("read data pending outside a sweep");

    a_count_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WORK) |=> (count_reg == $past(count_reg))
            || (count_reg == $past(count_reg) + CW'(1))
            || (count_reg == $past(count_reg) - CW'(1)))
        else $error("count moved by more than one in a sweep");

endmodule
